@@ design/tcap_tie_pkg.sv @@
// shared types and constants for the tcap transaction id extractor
package tcap_tie_pkg;

    localparam logic [7:0] BYTE_BEGIN    = 8'h62;
    localparam logic [7:0] BYTE_ABORT    = 8'h65;
    localparam logic [7:0] BYTE_END      = 8'h64;
    localparam logic [7:0] BYTE_CONTINUE = 8'h67;
    localparam logic [7:0] TAG_ORIG_ID   = 8'h48;
    localparam logic [7:0] TAG_DEST_ID   = 8'h49;
    localparam logic [6:0] LEN_MASK      = 7'h7F;
    localparam logic [15:0] SCAN_LIMIT_RESET = 16'd512;

    localparam logic [2:0] TYPE_UNKNOWN  = 3'd0;
    localparam logic [2:0] TYPE_BEGIN    = 3'd1;
    localparam logic [2:0] TYPE_ABORT    = 3'd2;
    localparam logic [2:0] TYPE_END      = 3'd3;
    localparam logic [2:0] TYPE_CONTINUE = 3'd4;

    localparam logic REG_SCAN_LIMIT = 1'b0;

    typedef enum logic [2:0] {
        PH_TYPE,
        PH_OLEN,
        PH_OLEN_MORE,
        PH_TAG,
        PH_LEN,
        PH_LEN_MORE,
        PH_VALUE
    } t_phase;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } t_in_req;

    typedef struct packed {
        logic [2:0]  msg_type;
        logic [31:0] orig_id;
        logic [31:0] dest_id;
        logic        id_missing;
    } t_out_res;

endpackage

@@ design/tcap_transaction_id_extractor_unit.sv @@
// tcap transaction id extractor: byte-serial ber tlv walker with one result per message
//
// usage
//   input channel: one message byte per request with a last-byte flag, valid/ready
//   output channel: one result per message (type, origin id, destination id,
//     missing-id flag), valid/ready, issued for the request that carries last_byte
//   config: apb-style port, scan_limit at byte address 0, writes while idle
// timing
//   one request per cycle sustained while no result waits unaccepted; every byte
//   is parsed in the cycle it is accepted by the tlv state machine, so the result
//   register is loaded at the edge that accepts the last byte and shows in the
//   following cycle
// reset
//   synchronous active-low reset clears the parser, the held ids and the output
//   valid, and sets scan_limit to 512
// stall
//   a waiting result holds in the output register; a new byte is still taken
//   while the receiver takes the result in the same cycle, otherwise input
//   ready drops until the result leaves
module tcap_transaction_id_extractor_unit (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  tcap_tie_pkg::t_in_req    i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output tcap_tie_pkg::t_out_res   o_out_data,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    import tcap_tie_pkg::*;

    localparam logic [16:0] POS_SAT = 17'h10000;

    logic [15:0] r_scan_limit;
    logic [16:0] r_pos,       n_pos;
    t_phase      r_phase,     n_phase;
    logic        r_stopped,   n_stopped;
    logic [7:0]  r_tag,       n_tag;
    logic [31:0] r_len_acc,   n_len_acc;
    logic [2:0]  r_len_left,  n_len_left;
    logic [30:0] r_val_left,  n_val_left;
    logic        r_is_id,     n_is_id;
    logic [31:0] r_id_acc,    n_id_acc;
    logic [31:0] r_orig,      n_orig;
    logic [31:0] r_dest,      n_dest;
    logic [2:0]  r_type,      n_type;
    logic        r_out_valid;
    t_out_res    r_out_data,  n_out_data;

    logic        in_fire;
    logic        cfg_write;
    logic [7:0]  b;
    logic [31:0] more_acc;
    logic [6:0]  lf_count;
    logic        len_short;

    assign in_fire    = i_in_valid && o_in_ready;
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign b          = i_in_data.in_byte;
    assign more_acc   = {r_len_acc[23:0], b};
    assign lf_count   = b[6:0] & LEN_MASK;
    assign len_short  = !b[7];

    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_SCAN_LIMIT) ? {16'd0, r_scan_limit} : 32'd0;

    // phase sequencing
    always_comb begin
        n_phase = r_phase;
        if (in_fire) begin
            if (i_in_data.last_byte) begin
                n_phase = PH_TYPE;
            end else if (!r_stopped) begin
                case (r_phase)
                    PH_TYPE: begin
                        if (b == BYTE_BEGIN || b == BYTE_ABORT || b == BYTE_END ||
                            b == BYTE_CONTINUE) begin
                            n_phase = PH_OLEN;
                        end
                    end
                    PH_OLEN: begin
                        if (len_short) begin
                            n_phase = PH_TAG;
                        end else if (lf_count != 7'd0 && lf_count <= 7'd4) begin
                            n_phase = PH_OLEN_MORE;
                        end
                    end
                    PH_LEN: begin
                        if (len_short) begin
                            n_phase = (b == 8'd0) ? PH_TAG : PH_VALUE;
                        end else if (lf_count != 7'd0 && lf_count <= 7'd4) begin
                            n_phase = PH_LEN_MORE;
                        end
                    end
                    PH_OLEN_MORE: begin
                        if (r_len_left == 3'd1 && !more_acc[31]) begin
                            n_phase = PH_TAG;
                        end
                    end
                    PH_LEN_MORE: begin
                        if (r_len_left == 3'd1 && !more_acc[31]) begin
                            n_phase = (more_acc == 32'd0) ? PH_TAG : PH_VALUE;
                        end
                    end
                    PH_TAG: begin
                        if (r_pos < {1'b0, r_scan_limit}) begin
                            n_phase = PH_LEN;
                        end
                    end
                    PH_VALUE: begin
                        if (r_val_left == 31'd1) begin
                            n_phase = PH_TAG;
                        end
                    end
                    default: n_phase = PH_TYPE;
                endcase
            end
        end
    end

    // datapath and result
    always_comb begin
        n_pos      = r_pos;
        n_stopped  = r_stopped;
        n_tag      = r_tag;
        n_len_acc  = r_len_acc;
        n_len_left = r_len_left;
        n_val_left = r_val_left;
        n_is_id    = r_is_id;
        n_id_acc   = r_id_acc;
        n_orig     = r_orig;
        n_dest     = r_dest;
        n_type     = r_type;
        n_out_data = r_out_data;
        if (in_fire) begin
            n_pos = (r_pos == POS_SAT) ? r_pos : r_pos + 17'd1;
            if (!r_stopped) begin
                case (r_phase)
                    PH_TYPE: begin
                        case (b)
                            BYTE_BEGIN:    n_type = TYPE_BEGIN;
                            BYTE_ABORT:    n_type = TYPE_ABORT;
                            BYTE_END:      n_type = TYPE_END;
                            BYTE_CONTINUE: n_type = TYPE_CONTINUE;
                            default: begin
                                n_type    = TYPE_UNKNOWN;
                                n_stopped = 1'b1;
                            end
                        endcase
                    end
                    PH_OLEN, PH_LEN: begin
                        if (len_short) begin
                            n_len_acc = {24'd0, b};
                            if (r_phase == PH_LEN) begin
                                n_id_acc   = 32'd0;
                                n_val_left = {23'd0, b};
                                n_is_id    = (r_tag == TAG_ORIG_ID || r_tag == TAG_DEST_ID) &&
                                             b >= 8'd1 && b <= 8'd4;
                            end
                        end else if (lf_count == 7'd0 || lf_count > 7'd4) begin
                            n_stopped = 1'b1;
                        end else begin
                            n_len_acc  = 32'd0;
                            n_len_left = lf_count[2:0];
                        end
                    end
                    PH_OLEN_MORE, PH_LEN_MORE: begin
                        n_len_acc  = more_acc;
                        n_len_left = r_len_left - 3'd1;
                        if (r_len_left == 3'd1) begin
                            if (more_acc[31]) begin
                                n_stopped = 1'b1;
                            end else if (r_phase == PH_LEN_MORE) begin
                                n_id_acc   = 32'd0;
                                n_val_left = more_acc[30:0];
                                n_is_id    = (r_tag == TAG_ORIG_ID || r_tag == TAG_DEST_ID) &&
                                             more_acc >= 32'd1 && more_acc <= 32'd4;
                            end
                        end
                    end
                    PH_TAG: begin
                        if (r_pos >= {1'b0, r_scan_limit}) begin
                            n_stopped = 1'b1;
                        end else begin
                            n_tag = b;
                        end
                    end
                    PH_VALUE: begin
                        if (r_is_id) begin
                            n_id_acc = {r_id_acc[23:0], b};
                        end
                        n_val_left = r_val_left - 31'd1;
                        if (r_val_left == 31'd1 && r_is_id) begin
                            if (r_tag == TAG_ORIG_ID) begin
                                n_orig = {r_id_acc[23:0], b};
                            end else begin
                                n_dest = {r_id_acc[23:0], b};
                            end
                        end
                    end
                    default: n_stopped = 1'b1;
                endcase
            end
            if (i_in_data.last_byte) begin
                // short message or unknown type reports all zero
                if (r_pos == 17'd0 || n_type == TYPE_UNKNOWN) begin
                    n_out_data.msg_type   = TYPE_UNKNOWN;
                    n_out_data.orig_id    = 32'd0;
                    n_out_data.dest_id    = 32'd0;
                    n_out_data.id_missing = 1'b0;
                end else begin
                    n_out_data.msg_type   = n_type;
                    n_out_data.orig_id    = n_orig;
                    n_out_data.dest_id    = n_dest;
                    n_out_data.id_missing = (n_type == TYPE_BEGIN) ? (n_orig == 32'd0)
                                                                   : (n_dest == 32'd0);
                end
                n_pos      = 17'd0;
                n_stopped  = 1'b0;
                n_tag      = 8'd0;
                n_len_acc  = 32'd0;
                n_len_left = 3'd0;
                n_val_left = 31'd0;
                n_is_id    = 1'b0;
                n_id_acc   = 32'd0;
                n_orig     = 32'd0;
                n_dest     = 32'd0;
                n_type     = TYPE_UNKNOWN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_limit <= SCAN_LIMIT_RESET;
            r_pos        <= 17'd0;
            r_phase      <= PH_TYPE;
            r_stopped    <= 1'b0;
            r_tag        <= 8'd0;
            r_len_acc    <= 32'd0;
            r_len_left   <= 3'd0;
            r_val_left   <= 31'd0;
            r_is_id      <= 1'b0;
            r_id_acc     <= 32'd0;
            r_orig       <= 32'd0;
            r_dest       <= 32'd0;
            r_type       <= TYPE_UNKNOWN;
            r_out_valid  <= 1'b0;
        end else begin
            if (cfg_write && paddr[2] == REG_SCAN_LIMIT) begin
                r_scan_limit <= pwdata[15:0];
            end
            r_pos      <= n_pos;
            r_phase    <= n_phase;
            r_stopped  <= n_stopped;
            r_tag      <= n_tag;
            r_len_acc  <= n_len_acc;
            r_len_left <= n_len_left;
            r_val_left <= n_val_left;
            r_is_id    <= n_is_id;
            r_id_acc   <= n_id_acc;
            r_orig     <= n_orig;
            r_dest     <= n_dest;
            r_type     <= n_type;
            if (in_fire && i_in_data.last_byte) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

@@ design/tcap_tie_checker.sv @@
// port-level checks for the tcap transaction id extractor and their bind
module tcap_tie_checker (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     o_in_ready,
    input  tcap_tie_pkg::t_in_req    i_in_data,
    input  logic                     o_out_valid,
    input  logic                     i_out_ready,
    input  tcap_tie_pkg::t_out_res   o_out_data
);
    import tcap_tie_pkg::*;

    // a stalled result stays put
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result dropped or changed");

    // a last-byte request always yields a result on the next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.last_byte |=> o_out_valid)
        else $error("no result after last byte");

    // no result without a last-byte request
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_valid && o_in_ready && i_in_data.last_byte) && !(o_out_valid && !i_out_ready)
        |=> !o_out_valid)
        else $error("result without last byte");

    // unknown type reports nothing else
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.msg_type == TYPE_UNKNOWN |->
        o_out_data.orig_id == 32'd0 && o_out_data.dest_id == 32'd0 && !o_out_data.id_missing)
        else $error("unknown type with nonzero fields");

    // missing flag matches the id the type needs
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.msg_type != TYPE_UNKNOWN |->
        o_out_data.id_missing == ((o_out_data.msg_type == TYPE_BEGIN) ?
            (o_out_data.orig_id == 32'd0) : (o_out_data.dest_id == 32'd0)))
        else $error("id_missing inconsistent");

endmodule

bind tcap_transaction_id_extractor_unit tcap_tie_checker u_tcap_tie_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

@@ bench/tcap_transaction_id_extractor_unit_test.sv @@
// testbench for tcap_transaction_id_extractor_unit: directed and random messages
`timescale 1ns / 1ps

module tcap_transaction_id_extractor_unit_test;

    import tcap_tie_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam logic [2:0] SCAN_LIMIT_ADDR = {REG_SCAN_LIMIT, 2'b00};
    localparam logic [15:0] PHASE_LIMITS [7] = '{16'd512, 16'd65535, 16'd1, 16'd0, 16'd6,
                                                 16'd12, 16'd40};

    typedef struct packed {
        logic [15:0]  limit;
        logic [4:0]   n_bytes;
        logic [127:0] seq;
        logic         fixed;
        t_out_res     res;
    } t_directed_msg;

    localparam t_directed_msg DIRECTED_MSGS [24] = '{
        '{16'd512, 5'd1, 128'h62, 1'b1, '{TYPE_UNKNOWN, 32'h0, 32'h0, 1'b0}},
        '{16'd512, 5'd5, 128'h11_00_48_01_05, 1'b1, '{TYPE_UNKNOWN, 32'h0, 32'h0, 1'b0}},
        '{16'd512, 5'd8, 128'h62_06_48_04_DE_AD_BE_EF, 1'b1,
          '{TYPE_BEGIN, 32'hDEADBEEF, 32'h0, 1'b0}},
        '{16'd512, 5'd5, 128'h64_03_49_01_FF, 1'b1, '{TYPE_END, 32'h0, 32'hFF, 1'b0}},
        '{16'd512, 5'd2, 128'h65_00, 1'b1, '{TYPE_ABORT, 32'h0, 32'h0, 1'b1}},
        '{16'd512, 5'd12, 128'h67_81_10_48_02_12_34_49_03_AB_CD_EF, 1'b1,
          '{TYPE_CONTINUE, 32'h1234, 32'hABCDEF, 1'b0}},
        '{16'd512, 5'd5, 128'h62_80_48_01_05, 1'b1, '{TYPE_BEGIN, 32'h0, 32'h0, 1'b1}},
        '{16'd512, 5'd8, 128'h62_05_48_01_07_49_85_01, 1'b1,
          '{TYPE_BEGIN, 32'h7, 32'h0, 1'b0}},
        '{16'd512, 5'd9, 128'h64_10_49_84_80_00_00_00_01, 1'b1,
          '{TYPE_END, 32'h0, 32'h0, 1'b1}},
        '{16'd512, 5'd10, 128'h67_10_49_84_00_00_00_02_AA_BB, 1'b0, '0},
        '{16'd512, 5'd6, 128'h62_05_48_04_11_22, 1'b0, '0},
        '{16'd512, 5'd14, 128'h62_00_48_00_48_05_01_02_03_04_05_48_01_09, 1'b0, '0},
        '{16'd512, 5'd6, 128'h64_04_49_02_00_00, 1'b0, '0},
        '{16'd512, 5'd8, 128'h62_00_48_01_01_48_01_02, 1'b0, '0},
        '{16'd512, 5'd10, 128'h62_00_30_03_48_01_05_48_01_06, 1'b0, '0},
        '{16'd512, 5'd8, 128'h67_00_49_04_FF_FF_FF_FF, 1'b1,
          '{TYPE_CONTINUE, 32'h0, 32'hFFFFFFFF, 1'b0}},
        '{16'd512, 5'd5, 128'h62_00_48_82_00, 1'b0, '0},
        '{16'd512, 5'd9, 128'h62_84_80_00_00_00_48_01_05, 1'b1,
          '{TYPE_BEGIN, 32'h0, 32'h0, 1'b1}},
        '{16'd512, 5'd2, 128'h00_00, 1'b1, '{TYPE_UNKNOWN, 32'h0, 32'h0, 1'b0}},
        '{16'd512, 5'd1, 128'hFF, 1'b1, '{TYPE_UNKNOWN, 32'h0, 32'h0, 1'b0}},
        '{16'd3, 5'd5, 128'h62_00_48_01_05, 1'b0, '0},
        '{16'd5, 5'd8, 128'h62_00_48_01_05_48_01_06, 1'b0, '0},
        '{16'd0, 5'd5, 128'h64_00_49_01_05, 1'b0, '0},
        '{16'd65535, 5'd5, 128'h64_00_49_01_05, 1'b0, '0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_req     i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_res    o_out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // predictor state
    logic [15:0] scan_limit_cfg = SCAN_LIMIT_RESET;
    logic [31:0] pos;
    t_phase      phase;
    logic [7:0]  cur_tag;
    logic [31:0] len_acc;
    logic [2:0]  len_left;
    logic [31:0] val_left;
    logic [31:0] id_acc;
    logic [31:0] orig_held;
    logic [31:0] dest_held;
    logic [2:0]  type_held;
    logic        stopped;

    t_out_res    awaited_results [$];
    logic [7:0]  msg_bytes [$];
    int          mismatches = 0;
    int          cycle_count = 0;
    logic        steady_flow = 1'b0;
    logic        hold_off_armed = 1'b0;
    int          hold_off_left = 0;

    tcap_transaction_id_extractor_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 i_clk = ~i_clk;

    function automatic void clear_message();
        pos = '0;
        phase = PH_TYPE;
        cur_tag = '0;
        len_acc = '0;
        len_left = '0;
        val_left = '0;
        id_acc = '0;
        orig_held = '0;
        dest_held = '0;
        type_held = TYPE_UNKNOWN;
        stopped = 1'b0;
    endfunction

    function automatic void start_value();
        if (len_acc[31]) begin
            stopped = 1'b1;
        end else begin
            id_acc = '0;
            val_left = len_acc;
            phase = (len_acc == 0) ? PH_TAG : PH_VALUE;
        end
    endfunction

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10) $display("mismatch: %s", what);
    endtask

    task automatic parse_request(input t_in_req req, input logic use_fixed,
                                 input t_out_res fixed_res);
        logic [6:0] n_len;
        logic       id_item;
        t_out_res   res;
        id_item = (cur_tag == TAG_ORIG_ID || cur_tag == TAG_DEST_ID) &&
                  len_acc >= 1 && len_acc <= 4;
        if (!stopped) begin
            case (phase)
                PH_TYPE: begin
                    case (req.in_byte)
                        BYTE_BEGIN:    type_held = TYPE_BEGIN;
                        BYTE_ABORT:    type_held = TYPE_ABORT;
                        BYTE_END:      type_held = TYPE_END;
                        BYTE_CONTINUE: type_held = TYPE_CONTINUE;
                        default: begin
                            type_held = TYPE_UNKNOWN;
                            stopped = 1'b1;
                        end
                    endcase
                    if (!stopped) phase = PH_OLEN;
                end
                PH_OLEN, PH_LEN: begin
                    if (!req.in_byte[7]) begin
                        len_acc = {24'b0, req.in_byte};
                        if (phase == PH_OLEN) phase = PH_TAG;
                        else start_value();
                    end else begin
                        n_len = req.in_byte[6:0] & LEN_MASK;
                        if (n_len == 0 || n_len > 4) begin
                            stopped = 1'b1;
                        end else begin
                            len_acc = '0;
                            len_left = n_len[2:0];
                            phase = (phase == PH_OLEN) ? PH_OLEN_MORE : PH_LEN_MORE;
                        end
                    end
                end
                PH_OLEN_MORE, PH_LEN_MORE: begin
                    len_acc = {len_acc[23:0], req.in_byte};
                    len_left = len_left - 3'd1;
                    if (len_left == 0) begin
                        if (phase == PH_LEN_MORE) start_value();
                        else if (len_acc[31]) stopped = 1'b1;
                        else phase = PH_TAG;
                    end
                end
                PH_TAG: begin
                    if (pos >= {16'b0, scan_limit_cfg}) begin
                        stopped = 1'b1;
                    end else begin
                        cur_tag = req.in_byte;
                        phase = PH_LEN;
                    end
                end
                PH_VALUE: begin
                    if (id_item) id_acc = {id_acc[23:0], req.in_byte};
                    val_left = val_left - 1;
                    if (val_left == 0) begin
                        if (id_item) begin
                            if (cur_tag == TAG_ORIG_ID) orig_held = id_acc;
                            else dest_held = id_acc;
                        end
                        phase = PH_TAG;
                    end
                end
                default: stopped = 1'b1;
            endcase
        end
        if (pos != 32'hFFFF_FFFF) pos++;
        if (req.last_byte) begin
            res.msg_type = type_held;
            res.orig_id = orig_held;
            res.dest_id = dest_held;
            res.id_missing = 1'b0;
            if (pos < 2 || type_held == TYPE_UNKNOWN) res = '0;
            else if (type_held == TYPE_BEGIN) res.id_missing = (orig_held == 0);
            else res.id_missing = (dest_held == 0);
            awaited_results.push_back(use_fixed ? fixed_res : res);
            clear_message();
        end
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic push_request(input t_in_req req, input logic use_fixed,
                                input t_out_res fixed_res);
        while (!steady_flow && $urandom_range(99) < 22) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= req;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        parse_request(req, use_fixed, fixed_res);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_scan_limit(input logic [15:0] limit);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= SCAN_LIMIT_ADDR;
        pwdata <= {16'($urandom), limit};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        scan_limit_cfg = limit;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata[15:0] !== limit)
            note_mismatch($sformatf("scan_limit read %h expected %h", prdata[15:0], limit));
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic append_length(input logic [31:0] len);
        int unsigned form;
        int          n;
        form = $urandom_range(99);
        if (form < 3) begin
            msg_bytes.push_back(form == 0 ? 8'h80 : 8'(8'h85 + $urandom_range(0, 122)));
        end else if (form < 6) begin
            msg_bytes.push_back(8'h84);
            msg_bytes.push_back(8'($urandom_range(128, 255)));
            repeat (3) msg_bytes.push_back(8'($urandom));
        end else if (form < 60 && len < 128) begin
            msg_bytes.push_back(len[7:0]);
        end else begin
            n = $urandom_range(1, 4);
            if (n < 4 && (len >> (8 * n)) != 0) n = 4;
            msg_bytes.push_back(8'h80 | 8'(n));
            for (int i = n - 1; i >= 0; i--) msg_bytes.push_back(8'(len >> (8 * i)));
        end
    endtask

    // receiver side
    always @(negedge i_clk) begin
        if (hold_off_armed) begin
            hold_off_armed = 1'b0;
            hold_off_left = HOLD_OFF_CYCLES;
        end
        if (hold_off_left != 0) begin
            hold_off_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= steady_flow || ($urandom_range(99) >= 22);
        end
    end

    always @(posedge i_clk) begin
        t_out_res want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (awaited_results.size() == 0) begin
                note_mismatch($sformatf("unexpected result %p", o_out_data));
            end else begin
                want = awaited_results.pop_front();
                if (o_out_data.msg_type !== want.msg_type ||
                    o_out_data.orig_id !== want.orig_id ||
                    o_out_data.dest_id !== want.dest_id ||
                    o_out_data.id_missing !== want.id_missing)
                    note_mismatch($sformatf(
                        "expected type %0d orig %h dest %h missing %b, got %0d %h %h %b",
                        want.msg_type, want.orig_id, want.dest_id, want.id_missing,
                        o_out_data.msg_type, o_out_data.orig_id, o_out_data.dest_id,
                        o_out_data.id_missing));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        t_in_req     req;
        t_directed_msg row;
        int          phase_idx;
        int          phase_bytes;
        int unsigned roll;
        int unsigned tag_roll;
        int unsigned vlen;
        logic        zero_value;
        clear_message();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        wait_idle();

        // directed messages
        for (int r = 0; r < 24; r++) begin
            row = DIRECTED_MSGS[r];
            if (row.limit != scan_limit_cfg) begin
                wait_idle();
                write_scan_limit(row.limit);
            end
            for (int i = 0; i < int'(row.n_bytes); i++) begin
                req.in_byte = row.seq[8 * (int'(row.n_bytes) - 1 - i) +: 8];
                req.last_byte = (i == int'(row.n_bytes) - 1);
                push_request(req, row.fixed, row.res);
            end
        end

        // random messages, one scan limit per phase
        for (phase_idx = 0; phase_idx < 8; phase_idx++) begin
            wait_idle();
            write_scan_limit(phase_idx < 7 ? PHASE_LIMITS[phase_idx]
                                           : 16'($urandom_range(2, 60)));
            steady_flow = (phase_idx == 2);
            if (phase_idx == 5) hold_off_armed = 1'b1;
            phase_bytes = 0;
            while (phase_bytes < 160) begin
                msg_bytes.delete();
                roll = $urandom_range(99);
                if (roll < 8) begin
                    repeat ($urandom_range(1, 12)) msg_bytes.push_back(8'($urandom));
                end else begin
                    case ($urandom_range(9))
                        0, 1, 9: msg_bytes.push_back(BYTE_BEGIN);
                        2, 3:    msg_bytes.push_back(BYTE_ABORT);
                        4, 5:    msg_bytes.push_back(BYTE_END);
                        6, 7:    msg_bytes.push_back(BYTE_CONTINUE);
                        default: msg_bytes.push_back(8'($urandom));
                    endcase
                    append_length($urandom_range(0, 300));
                    repeat ($urandom_range(0, 4)) begin
                        tag_roll = $urandom_range(99);
                        if (tag_roll < 40) msg_bytes.push_back(TAG_ORIG_ID);
                        else if (tag_roll < 80) msg_bytes.push_back(TAG_DEST_ID);
                        else msg_bytes.push_back(8'($urandom));
                        tag_roll = $urandom_range(99);
                        if (tag_roll < 10) vlen = 0;
                        else if (tag_roll < 80) vlen = $urandom_range(1, 4);
                        else vlen = $urandom_range(5, 8);
                        append_length(vlen);
                        zero_value = ($urandom_range(9) == 0);
                        repeat (vlen) msg_bytes.push_back(zero_value ? 8'h00 : 8'($urandom));
                    end
                    // cut the message short now and then
                    if ($urandom_range(99) < 12 && msg_bytes.size() > 1)
                        repeat ($urandom_range(1, msg_bytes.size() - 1)) void'(msg_bytes.pop_back());
                end
                for (int i = 0; i < msg_bytes.size(); i++) begin
                    req.in_byte = msg_bytes[i];
                    req.last_byte = (i == msg_bytes.size() - 1);
                    push_request(req, 1'b0, '0);
                end
                if (roll >= 8) phase_bytes += msg_bytes.size();
            end
        end

        steady_flow = 1'b0;
        wait_idle();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
